// ===== rtl/akl_pkg.sv =====
// Shared types and constants for the address-keyed label table.
// Used by akl_ctrl and address_keyed_label_table; no dependencies.
package akl_pkg;

    localparam int CAPACITY   = 32;
    localparam int TEXT_CHARS = 8;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int USED_W = 6;
    localparam int USED_MAX = 63;

    localparam logic [1:0] CMD_LEARN = 2'd0;
    localparam logic [1:0] CMD_FIND  = 2'd1;
    localparam logic [1:0] CMD_AGE   = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [31:0] FORGET_RESET = 32'd60;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  addr_kind;
        logic [23:0] address;
        logic [63:0] label_text;
        logic [31:0] time_now;
    } akl_req_t;

    typedef struct packed {
        logic              found;
        logic [63:0]       found_text;
        logic [USED_W-1:0] entries_used;
    } akl_rsp_t;

    typedef struct packed {
        logic [7:0]  kind;
        logic [23:0] address;
        logic [31:0] heard;
        logic [63:0] label;
    } akl_entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             we;
        logic [IDX_W-1:0] wr_addr;
        akl_entry_t       wr_data;
    } akl_ram_cmd_t;

endpackage

// ===== rtl/akl_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
module akl_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 128,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/akl_ctrl.sv =====
// Sequencer of the label table: scans the entry RAM, keeps valid bits and
// the use count, selects the learn target. Depends on akl_pkg.
module akl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  akl_pkg::akl_req_t      req,
    input  logic [31:0]            forget_seconds,
    output logic                   res_valid,
    output akl_pkg::akl_rsp_t      res,
    input  logic                   res_take,
    output akl_pkg::akl_ram_cmd_t  ram_cmd,
    input  akl_pkg::akl_entry_t    ram_rd_data
);
    import akl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_RESP  = 4'b1000
    } akl_state_t;

    akl_state_t          state_reg, state_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                match_hit_reg, match_hit_next;
    logic                free_hit_reg, free_hit_next;
    logic                old_hit_reg, old_hit_next;

    // payload, no reset
    akl_req_t            req_reg, req_next;
    logic [IDX_W-1:0]    match_idx_reg, match_idx_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]    old_idx_reg, old_idx_next;
    logic [31:0]         old_time_reg, old_time_next;
    logic [63:0]         match_text_reg, match_text_next;

    logic                cur_valid;
    logic                cur_hit;
    logic                cur_keep;
    logic [IDX_W-1:0]    wr_idx;
    logic                is_find;

    function automatic logic [63:0] trim_label(input logic [63:0] text);
        logic [63:0] kept;
        logic        live;
        kept = '0;
        live = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (i >= TEXT_CHARS || text[8*i +: 8] == 8'd0)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                kept[8*i +: 8] = text[8*i +: 8];
            end
        end
        return kept;
    endfunction

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign is_find   = (req_reg.cmd == CMD_FIND);

    assign cur_valid = valid_reg[cmp_idx_reg];
    assign cur_hit   = cur_valid && ram_rd_data.kind == req_reg.addr_kind
                       && ram_rd_data.address == req_reg.address;
    // entries heard in the future, or within the window, survive ageing
    assign cur_keep  = (req_reg.time_now < ram_rd_data.heard)
                       || ((req_reg.time_now - ram_rd_data.heard) <= forget_seconds);

    assign wr_idx = match_hit_reg ? match_idx_reg :
                    free_hit_reg  ? free_idx_reg  : old_idx_reg;

    always_comb
    begin
        res.found        = match_hit_reg && is_find;
        res.found_text   = (match_hit_reg && is_find) ? match_text_reg : 64'd0;
        res.entries_used = (32'(cnt_reg) > 32'(USED_MAX)) ? USED_W'(USED_MAX)
                                                           : USED_W'(cnt_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        issue_next      = issue_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        match_hit_next  = match_hit_reg;
        free_hit_next   = free_hit_reg;
        old_hit_next    = old_hit_reg;
        req_next        = req_reg;
        match_idx_next  = match_idx_reg;
        free_idx_next   = free_idx_reg;
        old_idx_next    = old_idx_reg;
        old_time_next   = old_time_reg;
        match_text_next = match_text_reg;

        ram_cmd                 = '0;
        ram_cmd.wr_addr         = wr_idx;
        ram_cmd.wr_data.kind    = req_reg.addr_kind;
        ram_cmd.wr_data.address = req_reg.address;
        ram_cmd.wr_data.heard   = req_reg.time_now;
        ram_cmd.wr_data.label   = trim_label(req_reg.label_text);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next       = req;
                    issue_next     = '0;
                    match_hit_next = 1'b0;
                    free_hit_next  = 1'b0;
                    old_hit_next   = 1'b0;
                    if (req.cmd == CMD_CLEAR)
                    begin
                        valid_next = '0;
                        cnt_next   = '0;
                        state_next = S_RESP;
                    end
                    else if (req.cmd == CMD_LEARN && req.label_text[7:0] == 8'd0)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue side: one RAM read per cycle
                if (issue_reg != CNT_W'(CAPACITY))
                begin
                    ram_cmd.rd_en   = 1'b1;
                    ram_cmd.rd_addr = issue_reg[IDX_W-1:0];
                    issue_next      = issue_reg + 1'b1;
                    cmp_vld_next    = 1'b1;
                    cmp_idx_next    = issue_reg[IDX_W-1:0];
                end
                // compare side: data of the read issued last cycle
                if (cmp_vld_reg)
                begin
                    if (cur_hit && !match_hit_reg)
                    begin
                        match_hit_next  = 1'b1;
                        match_idx_next  = cmp_idx_reg;
                        match_text_next = ram_rd_data.label;
                    end
                    if (!cur_valid && !free_hit_reg)
                    begin
                        free_hit_next = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                    if (cur_valid && (!old_hit_reg || ram_rd_data.heard < old_time_reg))
                    begin
                        old_hit_next  = 1'b1;
                        old_idx_next  = cmp_idx_reg;
                        old_time_next = ram_rd_data.heard;
                    end
                    if (req_reg.cmd == CMD_AGE && cur_valid && !cur_keep)
                    begin
                        valid_next[cmp_idx_reg] = 1'b0;
                        cnt_next                = cnt_reg - 1'b1;
                    end
                    if (issue_reg == CNT_W'(CAPACITY))
                    begin
                        state_next = (req_reg.cmd == CMD_LEARN) ? S_WRITE : S_RESP;
                    end
                end
            end

            S_WRITE:
            begin
                ram_cmd.we         = 1'b1;
                valid_next[wr_idx] = 1'b1;
                if (!valid_reg[wr_idx])
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            issue_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            match_hit_reg <= 1'b0;
            free_hit_reg  <= 1'b0;
            old_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            issue_reg     <= issue_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_idx_reg   <= cmp_idx_next;
            match_hit_reg <= match_hit_next;
            free_hit_reg  <= free_hit_next;
            old_hit_reg   <= old_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        match_idx_reg  <= match_idx_next;
        free_idx_reg   <= free_idx_next;
        old_idx_reg    <= old_idx_next;
        old_time_reg   <= old_time_next;
        match_text_reg <= match_text_next;
    end

`ifndef ASSERT_OFF
    a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) == 32'($countones(valid_reg)))
        else $error("use count out of step with valid bits");

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= 32'(CAPACITY))
        else $error("use count above capacity");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start");

    a_write_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> !cmp_vld_reg)
        else $error("entry write before scan drained");

    a_take_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> (state_reg == S_IDLE))
        else $error("result handed over but sequencer not idle");
`endif

endmodule

// ===== rtl/address_keyed_label_table.sv =====
// Address-keyed label table: a 32-entry associative store of short text labels.
// Top level; depends on akl_pkg, akl_ctrl and akl_ram.
//
// The table keeps CAPACITY entries in a single-port-read/single-port-write
// RAM (kind, address, heard time, 8-byte label per entry), with the valid
// bits and the use count in flip-flops, so reset empties the table at once
// and no clearing pass follows reset. One request transaction is worked on
// at a time. Learn, find and age each sweep the whole RAM, one entry per
// cycle through its registered read port, each entry compared in the
// cycle after its read; a learn then writes its entry in the S_WRITE
// state. Clear all and a learn with an empty label need no sweep.
// Learn updates the matching entry, else the lowest free entry, else the
// entry with the oldest heard time (lowest index on ties); the stored label
// is cut at the first zero byte. The RAM write happens only after the sweep
// has drained, so reads and writes of one entry never overlap. Results sit
// in an output register, so the next request is accepted while a response
// transaction still waits on rsp_ready. The forget_seconds register (reset
// 60) is written through the cfg channel, which is always ready, and should
// only be written while the block is idle.
module address_keyed_label_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  akl_pkg::akl_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output akl_pkg::akl_rsp_t rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data
);
    import akl_pkg::*;

    logic [31:0]  forget_reg;
    logic         rsp_valid_reg, rsp_valid_next;
    akl_rsp_t     rsp_reg;

    logic         res_valid;
    akl_rsp_t     res;
    logic         res_take;
    akl_ram_cmd_t ram_cmd;
    akl_entry_t   ram_rd_data;

    // config register: always able to take a write
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forget_reg <= FORGET_RESET;
        end
        else if (cfg_valid)
        begin
            forget_reg <= cfg_data;
        end
    end

    // output register: loads when empty or being drained this cycle
    assign res_take = res_valid && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    akl_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .forget_seconds (forget_reg),
        .res_valid      (res_valid),
        .res            (res),
        .res_take       (res_take),
        .ram_cmd        (ram_cmd),
        .ram_rd_data    (ram_rd_data)
    );

    akl_ram #(
        .DEPTH (CAPACITY),
        .WIDTH ($bits(akl_entry_t)),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (ram_cmd.rd_en),
        .rd_addr (ram_cmd.rd_addr),
        .rd_data (ram_rd_data),
        .we      (ram_cmd.we),
        .wr_addr (ram_cmd.wr_addr),
        .wr_data (ram_cmd.wr_data)
    );

endmodule

// ===== bench/akl_label_checker.sv =====
`timescale 1ns / 1ps
// Label table checker: keeps a shadow copy of the table and forget setting,
// predicts each response transaction and compares it field by field.
// Depends on akl_pkg only.
module akl_label_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  akl_pkg::akl_req_t req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  akl_pkg::akl_rsp_t rsp,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [31:0]       cfg_data,
    output int                mismatches,
    output int                awaiting
);
    import akl_pkg::*;

    localparam int MAX_PRINTED = 200;

    bit         shadow_used  [CAPACITY];
    akl_entry_t shadow_entry [CAPACITY];
    logic [31:0] shadow_forget;
    akl_rsp_t   predicted_rsp [$];
    akl_rsp_t   oldest;

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] seen);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t: %s: expected %0h, got %0h", $time, what, want, seen);
    endtask

    // stored label stops at the first zero byte, higher bytes read as zero
    function automatic logic [63:0] cut_label(input logic [63:0] text);
        logic [63:0] kept;
        bit          ended;
        kept  = '0;
        ended = 1'b0;
        for (int b = 0; b < TEXT_CHARS && b < 8; b++)
        begin
            if (text[8*b +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                kept[8*b +: 8] = text[8*b +: 8];
        end
        return kept;
    endfunction

    function automatic int key_slot(input logic [7:0] kind, input logic [23:0] addr);
        for (int i = 0; i < CAPACITY; i++)
            if (shadow_used[i] && shadow_entry[i].kind == kind
                && shadow_entry[i].address == addr)
                return i;
        return -1;
    endfunction

    function automatic akl_rsp_t apply_to_shadow(input akl_req_t r);
        akl_rsp_t res;
        int       slot;
        int       used;
        res  = '0;
        used = 0;
        case (r.cmd)
            CMD_LEARN:
            begin
                if (r.label_text[7:0] != 8'h00)
                begin
                    slot = key_slot(r.addr_kind, r.address);
                    if (slot < 0)
                    begin
                        // first free slot, else oldest heard time, lowest index on ties
                        slot = 0;
                        for (int i = CAPACITY - 1; i >= 0; i--)
                            if (!shadow_used[i])
                                slot = i;
                        if (shadow_used[slot])
                            for (int i = 1; i < CAPACITY; i++)
                                if (shadow_entry[i].heard < shadow_entry[slot].heard)
                                    slot = i;
                    end
                    shadow_used[slot]  = 1'b1;
                    shadow_entry[slot] = '{kind: r.addr_kind, address: r.address,
                                           heard: r.time_now,
                                           label: cut_label(r.label_text)};
                end
            end
            CMD_FIND:
            begin
                slot = key_slot(r.addr_kind, r.address);
                if (slot >= 0)
                begin
                    res.found      = 1'b1;
                    res.found_text = shadow_entry[slot].label;
                end
            end
            CMD_AGE:
            begin
                for (int i = 0; i < CAPACITY; i++)
                    if (shadow_used[i] && r.time_now >= shadow_entry[i].heard
                        && (r.time_now - shadow_entry[i].heard) > shadow_forget)
                    begin
                        shadow_used[i]  = 1'b0;
                        shadow_entry[i] = '0;
                    end
            end
            default:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    shadow_used[i]  = 1'b0;
                    shadow_entry[i] = '0;
                end
            end
        endcase
        for (int i = 0; i < CAPACITY; i++)
            used += int'(shadow_used[i]);
        res.entries_used = USED_W'((used > USED_MAX) ? USED_MAX : used);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_forget = FORGET_RESET;
            for (int i = 0; i < CAPACITY; i++)
            begin
                shadow_used[i]  = 1'b0;
                shadow_entry[i] = '0;
            end
            predicted_rsp.delete();
            mismatches = 0;
            awaiting   = 0;
        end
        else
        begin
            // the response leaving now belongs to an earlier request
            if (rsp_valid && rsp_ready)
            begin
                if (predicted_rsp.size() == 0)
                    report_mismatch("response with none pending", '0, rsp.found_text);
                else
                begin
                    oldest = predicted_rsp.pop_front();
                    if (rsp.found !== oldest.found)
                        report_mismatch("found", oldest.found, rsp.found);
                    if (rsp.found_text !== oldest.found_text)
                        report_mismatch("found_text", oldest.found_text, rsp.found_text);
                    if (rsp.entries_used !== oldest.entries_used)
                        report_mismatch("entries_used", oldest.entries_used,
                                        rsp.entries_used);
                end
            end
            if (req_valid && req_ready)
                predicted_rsp.push_back(apply_to_shadow(req));
            if (cfg_valid && cfg_ready)
                shadow_forget = cfg_data;
            awaiting = predicted_rsp.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Label table testbench top: clock, reset, request and cfg stimulus, response
// back-pressure and the verdict. Depends on akl_pkg, address_keyed_label_table
// and akl_label_checker.
module tb;
    import akl_pkg::*;

    localparam int NUM_KEYS    = 64;
    localparam int PHASE_ITEMS = 400;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE      = 40;   // a little over one full sweep

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    akl_req_t    req;
    logic        rsp_valid;
    logic        rsp_ready;
    akl_rsp_t    rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    int mismatches;
    int awaiting;

    // idling rates in percent, set by the stimulus; the receive rate is read by the response side
    int send_idle_pct;
    int rcv_idle_pct;
    // long response hold-offs: asked for by the stimulus, timed by the receiver
    int hold_off_asks;
    int hold_off_taken;
    int hold_left;

    // key pool: pairs that share an address or a kind, and near misses
    logic [7:0]  key_kind [NUM_KEYS];
    logic [23:0] key_addr [NUM_KEYS];
    // running seconds counter that the random requests carry
    logic [31:0] clock_s;

    always #5 clk = ~clk;

    address_keyed_label_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    akl_label_checker shadow (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // Every task below is entered and left just after a falling edge, so each
    // driven signal gets at most one assignment per time step.

    // Offer one request transaction, idling first at the current rate.
    task automatic send(input akl_req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted response has been taken.
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (awaiting != 0);
    endtask

    // forget_seconds may only change while the table is idle
    task automatic write_forget(input logic [31:0] seconds);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= seconds;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic akl_req_t make_req(input logic [1:0] cmd, input logic [7:0] kind,
                                          input logic [23:0] addr,
                                          input logic [63:0] text,
                                          input logic [31:0] seconds);
        akl_req_t r;
        r.cmd        = cmd;
        r.addr_kind  = kind;
        r.address    = addr;
        r.label_text = text;
        r.time_now   = seconds;
        return r;
    endfunction

    // Mostly terminated labels of 1..8 chars with junk past the terminator,
    // some empty ones, some fully random words.
    function automatic logic [63:0] random_label();
        logic [63:0] text;
        int          len;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        for (int b = 0; b < 8; b++)
        begin
            if (b < len)
                text[8*b +: 8] = 8'($urandom_range(1, 255));
            else if (b == len)
                text[8*b +: 8] = 8'h00;
            else
                text[8*b +: 8] = 8'($urandom);
        end
        return text;
    endfunction

    // Learn-heavy mix over the key pool so the table fills and entries get
    // replaced; clears are rare so that state builds up between them.
    function automatic akl_req_t random_request();
        akl_req_t r;
        int       pick;
        int       k;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            r.cmd = CMD_LEARN;
        else if (pick < 89)
            r.cmd = CMD_FIND;
        else if (pick < 99)
            r.cmd = CMD_AGE;
        else
            r.cmd = CMD_CLEAR;
        k = $urandom_range(0, NUM_KEYS - 1);
        r.addr_kind = key_kind[k];
        r.address   = key_addr[k];
        if ($urandom_range(0, 19) == 0)
        begin
            r.addr_kind = 8'($urandom);
            r.address   = 24'($urandom);
        end
        r.label_text = random_label();
        // time creeps forward, with equal stamps for ties, rare jumps and steps back
        pick = $urandom_range(0, 99);
        if (pick < 3)
            clock_s = $urandom;
        else if (pick < 6)
            clock_s = clock_s - $urandom_range(0, 50);
        else
            clock_s = clock_s + $urandom_range(0, 3);
        r.time_now = clock_s;
        return r;
    endfunction

    // Response side: random back-pressure, plus long hold-offs on request.
    initial
    begin
        rsp_ready      = 1'b0;
        hold_off_taken = 0;
        hold_left      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_asks != hold_off_taken)
            begin
                hold_off_taken = hold_off_asks;
                hold_left      = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Overall simulation time limit.
    initial
    begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        hold_off_asks = 0;
        clock_s       = 32'd1000;
        send_idle_pct = 21;
        rcv_idle_pct  = 45;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            key_kind[i] = 8'($urandom);
            key_addr[i] = 24'($urandom);
            if (i % 4 == 1)
                key_addr[i] = key_addr[i-1];
            if (i % 4 == 2)
                key_kind[i] = key_kind[i-1];
            if (i % 4 == 3)
                key_addr[i] = key_addr[i-1] ^ (24'h1 << $urandom_range(0, 23));
        end
        key_kind[0] = 8'h00;
        key_addr[0] = 24'h000000;
        key_kind[1] = 8'hFF;
        key_addr[1] = 24'hFFFFFF;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed part, forget_seconds still at its reset value of 60.
        // lookup in an empty table
        send(make_req(CMD_FIND, 8'h00, 24'h000000, '0, 32'd0));
        // empty label: low byte zero, nothing stored
        send(make_req(CMD_LEARN, 8'h5A, 24'h123456, 64'hFFFF_FFFF_FFFF_FF00, 32'd1));
        send(make_req(CMD_FIND, 8'h5A, 24'h123456, '0, 32'd1));
        // all-ones key, full eight-char label, latest possible time
        send(make_req(CMD_LEARN, 8'hFF, 24'hFFFFFF, '1, 32'hFFFF_FFFF));
        // "AB" with junk past the terminator
        send(make_req(CMD_LEARN, 8'h00, 24'h000000, 64'hDEAD_BEEF_0000_4241, 32'd0));
        // same address, other kind: a separate entry
        send(make_req(CMD_LEARN, 8'h01, 24'h000000, 64'h0000_0000_0000_005A, 32'd10));
        // eight nonzero chars kept whole
        send(make_req(CMD_LEARN, 8'h00, 24'h000001, 64'h0102_0304_0506_0708, 32'd20));
        send(make_req(CMD_FIND, 8'hFF, 24'hFFFFFF, '0, 32'd20));
        send(make_req(CMD_FIND, 8'h00, 24'h000000, '0, 32'd20));
        send(make_req(CMD_FIND, 8'h01, 24'h000000, '0, 32'd20));
        // update in place
        send(make_req(CMD_LEARN, 8'h00, 24'h000000, 64'hFFFF_FF00_0000_0043, 32'd30));
        send(make_req(CMD_FIND, 8'h00, 24'h000000, '0, 32'd30));
        // heard times ahead of now survive ageing
        send(make_req(CMD_AGE, 8'h00, 24'h000000, '0, 32'd5));
        // exactly 60 s old is kept, 70 s old goes
        send(make_req(CMD_AGE, 8'h00, 24'h000000, '0, 32'd80));
        send(make_req(CMD_AGE, 8'h00, 24'h000000, '0, 32'd81));
        send(make_req(CMD_FIND, 8'h01, 24'h000000, '0, 32'd81));
        send(make_req(CMD_CLEAR, 8'h00, 24'h000000, '0, 32'd81));
        send(make_req(CMD_FIND, 8'hFF, 24'hFFFFFF, '0, 32'd81));

        // Random phases: sender/receiver idling 21/45, then 45/21, then none,
        // each under its own forget setting (zero, maximum, a modest value).
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    write_forget(32'd0);
                end
                1:
                begin
                    send_idle_pct = 45;
                    rcv_idle_pct  = 21;
                    write_forget(32'hFFFF_FFFF);
                end
                default:
                begin
                    send_idle_pct = 0;
                    rcv_idle_pct  = 0;
                    write_forget($urandom_range(20, 300));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long hold-off so the output register fills and req_ready drops
                if (n == 50 && phase != 1)
                    hold_off_asks++;
                // now and then let every pending response come back first
                if (n % 150 == 149)
                    drain();
                send(random_request());
            end
        end

        drain();
        repeat (SETTLE) @(negedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== address_keyed_label_table.f =====
rtl/akl_pkg.sv
rtl/akl_ram.sv
rtl/akl_ctrl.sv
rtl/address_keyed_label_table.sv
bench/akl_label_checker.sv
bench/tb.sv
